/* src/tpfb_pkg.sv */
package tpfb_pkg;

  localparam int ROOT_W = 34;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int NUM_W  = 64;
  localparam int QUOT_W = 31;
  localparam int LANES  = 3;
  localparam int CFG_W  = 31;

  localparam logic [CFG_W-1:0] MIN_SEAM_RST = 31'd65536;
  localparam logic [CFG_W-1:0] MIN_SURF_RST = 31'd32768;

  localparam logic [1:0] ROW_X = 2'd0;
  localparam logic [1:0] ROW_Y = 2'd1;
  localparam logic [1:0] ROW_Z = 2'd2;

  typedef enum logic {
    CFG_MIN_SEAM = 1'b0,
    CFG_MIN_SURF = 1'b1
  } cfg_idx_t;

  typedef logic signed [31:0] pt_t;
  typedef logic signed [32:0] dif_t;
  typedef logic signed [31:0] ax_t;
  typedef logic signed [35:0] prp_t;
  typedef logic signed [63:0] acc_t;
  typedef logic signed [34:0] rnd_t;
  typedef logic signed [39:0] off_t;
  typedef logic [ROOT_W-1:0]  root_t;

  typedef pt_t  [2:0] pt3_t;
  typedef dif_t [2:0] dif3_t;
  typedef ax_t  [2:0] ax3_t;
  typedef prp_t [2:0] prp3_t;
  typedef ax3_t [2:0] frm_t;

  typedef struct packed {
    pt_t start_x;
    pt_t start_y;
    pt_t start_z;
    pt_t end_x;
    pt_t end_y;
    pt_t end_z;
    pt_t surface_x;
    pt_t surface_y;
    pt_t surface_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  row_index;
    ax_t         axis_x;
    ax_t         axis_y;
    ax_t         axis_z;
    off_t        row_offset;
    logic        frame_valid;
    logic [32:0] seam_length;
    logic        last_row;
  } out_item_t;

  typedef struct packed {
    pt3_t  s;
    dif3_t d;
    dif3_t v;
  } side1_t;

  typedef struct packed {
    pt3_t       s;
    dif3_t      v;
    logic [2:0] neg;
    root_t      len;
    logic       ok;
  } side2_t;

  typedef struct packed {
    pt3_t  s;
    dif3_t v;
    ax3_t  y;
    root_t len;
    logic  ok;
  } ctx_t;

  typedef struct packed {
    ctx_t  c;
    prp3_t p;
  } side3_t;

  typedef struct packed {
    ctx_t       c;
    logic [2:0] neg;
  } side4_t;

  function automatic dif_t ext33(input pt_t v);
    return {v[31], v};
  endfunction

  function automatic prp_t ext36(input dif_t v);
    return {{3{v[32]}}, v};
  endfunction

  // shift right by 30, rounding half away from zero
  function automatic rnd_t rnd30(input acc_t v);
    logic [63:0] mag;
    logic [63:0] m;
    rnd_t        r;
    mag = v[63] ? 64'(-v) : 64'(v);
    m   = (mag + 64'd536870912) >> 30;
    r   = rnd_t'(m);
    return v[63] ? -r : r;
  endfunction

  // |v| * 2^30 + len / 2
  function automatic logic [NUM_W-1:0] unum(input prp_t v, input root_t len);
    logic [35:0] mag;
    mag = v[35] ? 36'(-v) : 36'(v);
    return (NUM_W'(mag) << 30) + NUM_W'(len >> 1);
  endfunction

  function automatic ax_t sgn_ax(input logic neg, input logic [QUOT_W-1:0] q);
    ax_t m;
    m = ax_t'(q);
    return neg ? -m : m;
  endfunction

endpackage

/* src/tpfb_isqrt.sv */
module tpfb_isqrt #(
  parameter int RW = tpfb_pkg::ROOT_W,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  logic [2*RW-1:0] rad,
  input  logic [SW-1:0]   side_in,
  output logic            out_vld,
  output logic [RW-1:0]   root,
  output logic [SW-1:0]   side_out
);

  logic [2*RW-1:0] rem_r [RW];
  logic [RW-1:0]   rt_r  [RW];
  logic [SW-1:0]   sd_r  [RW];
  logic            vl_r  [RW];

  // one root bit per stage, remainder kept as rad - root^2
  for (genvar k = 0; k < RW; k++) begin : g_st
    localparam int B = RW - 1 - k;
    logic [2*RW-1:0] rem_i;
    logic [2*RW-1:0] trial;
    logic [RW-1:0]   rt_i;
    logic [SW-1:0]   sd_i;
    logic            vl_i;

    if (k == 0) begin : g_first
      assign rem_i = rad;
      assign rt_i  = '0;
      assign sd_i  = side_in;
      assign vl_i  = in_vld;
    end else begin : g_next
      assign rem_i = rem_r[k-1];
      assign rt_i  = rt_r[k-1];
      assign sd_i  = sd_r[k-1];
      assign vl_i  = vl_r[k-1];
    end

    assign trial = ((2*RW)'(rt_i) << (B + 1)) | ((2*RW)'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vl_r[k] <= 1'b0;
      end else if (en) begin
        vl_r[k] <= vl_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_i >= trial) begin
          rem_r[k] <= rem_i - trial;
          rt_r[k]  <= rt_i | (RW'(1) << B);
        end else begin
          rem_r[k] <= rem_i;
          rt_r[k]  <= rt_i;
        end
        sd_r[k] <= sd_i;
      end
    end
  end

  assign out_vld  = vl_r[RW-1];
  assign root     = rt_r[RW-1];
  assign side_out = sd_r[RW-1];

endmodule

/* src/tpfb_div.sv */
module tpfb_div #(
  parameter int NW = tpfb_pkg::NUM_W,
  parameter int DW = tpfb_pkg::ROOT_W,
  parameter int QW = tpfb_pkg::QUOT_W,
  parameter int NL = tpfb_pkg::LANES,
  parameter int SW = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic [NL-1:0][NW-1:0] num,
  input  logic [DW-1:0]         den,
  input  logic [SW-1:0]         side_in,
  output logic                  out_vld,
  output logic [NL-1:0][QW-1:0] quo,
  output logic [SW-1:0]         side_out
);

  logic [NL-1:0][NW-1:0] rem_r [QW];
  logic [NL-1:0][QW-1:0] quo_r [QW];
  logic [DW-1:0]         den_r [QW];
  logic [SW-1:0]         sd_r  [QW];
  logic                  vl_r  [QW];

  // restoring division, one quotient bit per stage, lanes share the divisor
  for (genvar k = 0; k < QW; k++) begin : g_st
    localparam int B = QW - 1 - k;
    logic [NL-1:0][NW-1:0] rem_i;
    logic [NL-1:0][QW-1:0] quo_i;
    logic [DW-1:0]         den_i;
    logic [SW-1:0]         sd_i;
    logic                  vl_i;
    logic [NW-1:0]         trial;

    if (k == 0) begin : g_first
      assign rem_i = num;
      assign quo_i = '0;
      assign den_i = den;
      assign sd_i  = side_in;
      assign vl_i  = in_vld;
    end else begin : g_next
      assign rem_i = rem_r[k-1];
      assign quo_i = quo_r[k-1];
      assign den_i = den_r[k-1];
      assign sd_i  = sd_r[k-1];
      assign vl_i  = vl_r[k-1];
    end

    assign trial = NW'(den_i) << B;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vl_r[k] <= 1'b0;
      end else if (en) begin
        vl_r[k] <= vl_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < NL; l++) begin
          if (rem_i[l] >= trial) begin
            rem_r[k][l] <= rem_i[l] - trial;
            quo_r[k][l] <= quo_i[l] | (QW'(1) << B);
          end else begin
            rem_r[k][l] <= rem_i[l];
            quo_r[k][l] <= quo_i[l];
          end
        end
        den_r[k] <= den_i;
        sd_r[k]  <= sd_i;
      end
    end
  end

  assign out_vld  = vl_r[QW-1];
  assign quo      = quo_r[QW-1];
  assign side_out = sd_r[QW-1];

endmodule

/* src/three_point_frame_builder_unit.sv */
// each item leaves as its x row first, the other two rows follow
// the three-row result port sets the rate: each item holds it until all its rows are taken
// the pipeline holds as a whole while the result register is full and its last stage holds an item
// reset: synchronous active-low rst_n clears valid bits and the row counter,
// and loads the minimum seam length (1.0 mm) and minimum surface offset (0.5 mm)
module three_point_frame_builder_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  tpfb_pkg::in_item_t       in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output tpfb_pkg::out_item_t      out_data,
  input  logic                     cfg_we,
  input  tpfb_pkg::cfg_idx_t       cfg_index,
  input  logic [tpfb_pkg::CFG_W-1:0] cfg_wdata
);

  import tpfb_pkg::*;

  logic en;
  logic free;

  logic [CFG_W-1:0] min_seam_r;
  logic [CFG_W-1:0] min_surf_r;

  // front
  logic     a_v_r;
  in_item_t a_d_r;
  logic     b_v_r;
  side1_t   b_c_r;
  logic     c_v_r;
  side1_t   c_c_r;
  logic [65:0] c_sq_r [3];
  logic     d_v_r;
  side1_t   d_c_r;
  logic [RAD_W-1:0] d_rad_r;

  logic     r1_vld;
  root_t    r1_root;
  side1_t   r1_side;

  logic     e_v_r;
  side2_t   e_c_r;
  logic [LANES-1:0][NUM_W-1:0] e_num_r;

  logic     q1_vld;
  logic [LANES-1:0][QUOT_W-1:0] q1_quo;
  side2_t   q1_side;

  // projection and perpendicular
  logic     f_v_r;
  ctx_t     f_c_r;
  logic     g_v_r;
  ctx_t     g_c_r;
  acc_t     g_m_r [3];
  logic     h_v_r;
  ctx_t     h_c_r;
  acc_t     h_dot_r;
  logic     i_v_r;
  ctx_t     i_c_r;
  rnd_t     i_proj_r;
  logic     j_v_r;
  ctx_t     j_c_r;
  acc_t     j_m_r [3];
  logic     k_v_r;
  side3_t   k_c_r;
  logic     l_v_r;
  side3_t   l_c_r;
  logic [71:0] l_sq_r [3];
  logic     m_v_r;
  side3_t   m_c_r;
  logic [RAD_W-1:0] m_rad_r;

  logic     r2_vld;
  root_t    r2_root;
  side3_t   r2_side;

  logic     n_v_r;
  side4_t   n_c_r;
  logic [LANES-1:0][NUM_W-1:0] n_num_r;

  logic     q2_vld;
  logic [LANES-1:0][QUOT_W-1:0] q2_quo;
  side4_t   q2_side;

  // z orientation, x axis, offsets
  logic     o_v_r;
  ctx_t     o_c_r;
  ax3_t     o_z_r;
  logic     p_v_r;
  ctx_t     p_c_r;
  ax3_t     p_z_r;
  acc_t     p_m_r [3];
  logic     q_v_r;
  ctx_t     q_c_r;
  ax3_t     q_z_r;
  logic     q_neg_r;
  logic     r_v_r;
  ctx_t     r_c_r;
  ax3_t     r_z_r;
  logic     cr_v_r;
  ctx_t     cr_c_r;
  ax3_t     cr_z_r;
  acc_t     cr_m_r [6];
  logic     xa_v_r;
  ctx_t     xa_c_r;
  frm_t     xa_f_r;
  logic     om_v_r;
  frm_t     om_f_r;
  root_t    om_len_r;
  logic     om_ok_r;
  acc_t     om_m_r [3][3];
  logic     os_v_r;
  frm_t     os_f_r;
  root_t    os_len_r;
  logic     os_ok_r;
  acc_t     os_sum_r [3];
  logic     of_v_r;
  frm_t     of_f_r;
  root_t    of_len_r;
  logic     of_ok_r;
  off_t     of_off_r [3];

  // result register
  logic       sr_busy_r;
  logic [1:0] sr_cnt_r;
  frm_t       sr_f_r;
  off_t       sr_off_r [3];
  logic       sr_ok_r;
  root_t      sr_len_r;

  assign free     = !sr_busy_r || (out_ready && sr_cnt_r == ROW_Z);
  assign en       = !of_v_r || free;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_seam_r <= MIN_SEAM_RST;
      min_surf_r <= MIN_SURF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_SEAM: min_seam_r <= cfg_wdata;
        CFG_MIN_SURF: min_surf_r <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r  <= 1'b0;
      b_v_r  <= 1'b0;
      c_v_r  <= 1'b0;
      d_v_r  <= 1'b0;
      e_v_r  <= 1'b0;
      f_v_r  <= 1'b0;
      g_v_r  <= 1'b0;
      h_v_r  <= 1'b0;
      i_v_r  <= 1'b0;
      j_v_r  <= 1'b0;
      k_v_r  <= 1'b0;
      l_v_r  <= 1'b0;
      m_v_r  <= 1'b0;
      n_v_r  <= 1'b0;
      o_v_r  <= 1'b0;
      p_v_r  <= 1'b0;
      q_v_r  <= 1'b0;
      r_v_r  <= 1'b0;
      cr_v_r <= 1'b0;
      xa_v_r <= 1'b0;
      om_v_r <= 1'b0;
      os_v_r <= 1'b0;
      of_v_r <= 1'b0;
    end else if (en) begin
      a_v_r  <= in_valid;
      b_v_r  <= a_v_r;
      c_v_r  <= b_v_r;
      d_v_r  <= c_v_r;
      e_v_r  <= r1_vld;
      f_v_r  <= q1_vld;
      g_v_r  <= f_v_r;
      h_v_r  <= g_v_r;
      i_v_r  <= h_v_r;
      j_v_r  <= i_v_r;
      k_v_r  <= j_v_r;
      l_v_r  <= k_v_r;
      m_v_r  <= l_v_r;
      n_v_r  <= r2_vld;
      o_v_r  <= q2_vld;
      p_v_r  <= o_v_r;
      q_v_r  <= p_v_r;
      r_v_r  <= q_v_r;
      cr_v_r <= r_v_r;
      xa_v_r <= cr_v_r;
      om_v_r <= xa_v_r;
      os_v_r <= om_v_r;
      of_v_r <= os_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_d_r <= in_data;

      // seam and surface differences
      b_c_r.s[0] <= a_d_r.start_x;
      b_c_r.s[1] <= a_d_r.start_y;
      b_c_r.s[2] <= a_d_r.start_z;
      b_c_r.d[0] <= ext33(a_d_r.end_x) - ext33(a_d_r.start_x);
      b_c_r.d[1] <= ext33(a_d_r.end_y) - ext33(a_d_r.start_y);
      b_c_r.d[2] <= ext33(a_d_r.end_z) - ext33(a_d_r.start_z);
      b_c_r.v[0] <= ext33(a_d_r.surface_x) - ext33(a_d_r.start_x);
      b_c_r.v[1] <= ext33(a_d_r.surface_y) - ext33(a_d_r.start_y);
      b_c_r.v[2] <= ext33(a_d_r.surface_z) - ext33(a_d_r.start_z);

      c_c_r <= b_c_r;
      for (int i = 0; i < 3; i++) begin
        c_sq_r[i] <= 66'($signed(b_c_r.d[i]) * $signed(b_c_r.d[i]));
      end

      d_c_r   <= c_c_r;
      d_rad_r <= RAD_W'(c_sq_r[0]) + RAD_W'(c_sq_r[1]) + RAD_W'(c_sq_r[2]);

      // seam length check and y numerators
      e_c_r.s   <= r1_side.s;
      e_c_r.v   <= r1_side.v;
      e_c_r.len <= r1_root;
      e_c_r.ok  <= (r1_root != '0) && (r1_root >= ROOT_W'(min_seam_r));
      for (int i = 0; i < 3; i++) begin
        e_c_r.neg[i] <= r1_side.d[i][32];
        e_num_r[i]   <= unum(ext36(r1_side.d[i]), r1_root);
      end

      f_c_r.s   <= q1_side.s;
      f_c_r.v   <= q1_side.v;
      f_c_r.len <= q1_side.len;
      f_c_r.ok  <= q1_side.ok;
      for (int i = 0; i < 3; i++) begin
        f_c_r.y[i] <= sgn_ax(q1_side.neg[i], q1_quo[i]);
      end

      // projection of the surface offset on y
      g_c_r <= f_c_r;
      for (int i = 0; i < 3; i++) begin
        g_m_r[i] <= acc_t'($signed(f_c_r.v[i]) * $signed(f_c_r.y[i]));
      end

      h_c_r   <= g_c_r;
      h_dot_r <= g_m_r[0] + g_m_r[1] + g_m_r[2];

      i_c_r    <= h_c_r;
      i_proj_r <= rnd30(h_dot_r);

      j_c_r <= i_c_r;
      for (int i = 0; i < 3; i++) begin
        j_m_r[i] <= acc_t'($signed(i_proj_r) * $signed(i_c_r.y[i]));
      end

      k_c_r.c <= j_c_r;
      for (int i = 0; i < 3; i++) begin
        k_c_r.p[i] <= ext36(j_c_r.v[i]) - prp_t'(rnd30(j_m_r[i]));
      end

      l_c_r <= k_c_r;
      for (int i = 0; i < 3; i++) begin
        l_sq_r[i] <= 72'($signed(k_c_r.p[i]) * $signed(k_c_r.p[i]));
      end

      m_c_r   <= l_c_r;
      m_rad_r <= RAD_W'(l_sq_r[0] + l_sq_r[1] + l_sq_r[2]);

      // surface offset check and z numerators
      n_c_r.c.s   <= r2_side.c.s;
      n_c_r.c.v   <= r2_side.c.v;
      n_c_r.c.y   <= r2_side.c.y;
      n_c_r.c.len <= r2_side.c.len;
      n_c_r.c.ok  <= r2_side.c.ok && (r2_root != '0) && (r2_root >= ROOT_W'(min_surf_r));
      for (int i = 0; i < 3; i++) begin
        n_c_r.neg[i] <= r2_side.p[i][35];
        n_num_r[i]   <= unum(r2_side.p[i], r2_root);
      end

      o_c_r <= q2_side.c;
      for (int i = 0; i < 3; i++) begin
        o_z_r[i] <= sgn_ax(q2_side.neg[i], q2_quo[i]);
      end

      // orientation away from the plate
      p_c_r <= o_c_r;
      p_z_r <= o_z_r;
      for (int i = 0; i < 3; i++) begin
        p_m_r[i] <= acc_t'($signed(o_c_r.v[i]) * $signed(o_z_r[i]));
      end

      q_c_r   <= p_c_r;
      q_z_r   <= p_z_r;
      q_neg_r <= acc_t'(p_m_r[0] + p_m_r[1] + p_m_r[2]) < 0;

      r_c_r.s   <= q_c_r.s;
      r_c_r.v   <= q_c_r.v;
      r_c_r.len <= q_c_r.len;
      r_c_r.ok  <= q_c_r.ok;
      for (int i = 0; i < 3; i++) begin
        r_c_r.y[i] <= q_c_r.ok ? q_c_r.y[i] : '0;
        r_z_r[i]   <= !q_c_r.ok ? '0 : (q_neg_r ? -q_z_r[i] : q_z_r[i]);
      end

      // x = y cross z
      cr_c_r    <= r_c_r;
      cr_z_r    <= r_z_r;
      cr_m_r[0] <= acc_t'($signed(r_c_r.y[1]) * $signed(r_z_r[2]));
      cr_m_r[1] <= acc_t'($signed(r_c_r.y[2]) * $signed(r_z_r[1]));
      cr_m_r[2] <= acc_t'($signed(r_c_r.y[2]) * $signed(r_z_r[0]));
      cr_m_r[3] <= acc_t'($signed(r_c_r.y[0]) * $signed(r_z_r[2]));
      cr_m_r[4] <= acc_t'($signed(r_c_r.y[0]) * $signed(r_z_r[1]));
      cr_m_r[5] <= acc_t'($signed(r_c_r.y[1]) * $signed(r_z_r[0]));

      xa_c_r    <= cr_c_r;
      xa_f_r[0] <= {ax_t'(rnd30(cr_m_r[4] - cr_m_r[5])),
                    ax_t'(rnd30(cr_m_r[2] - cr_m_r[3])),
                    ax_t'(rnd30(cr_m_r[0] - cr_m_r[1]))};
      xa_f_r[1] <= cr_c_r.y;
      xa_f_r[2] <= cr_z_r;

      // row offsets
      om_f_r   <= xa_f_r;
      om_len_r <= xa_c_r.len;
      om_ok_r  <= xa_c_r.ok;
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          om_m_r[k][i] <= acc_t'($signed(xa_f_r[k][i]) * $signed(xa_c_r.s[i]));
        end
      end

      os_f_r   <= om_f_r;
      os_len_r <= om_len_r;
      os_ok_r  <= om_ok_r;
      for (int k = 0; k < 3; k++) begin
        os_sum_r[k] <= om_m_r[k][0] + om_m_r[k][1] + om_m_r[k][2];
      end

      of_f_r   <= os_f_r;
      of_len_r <= os_len_r;
      of_ok_r  <= os_ok_r;
      for (int k = 0; k < 3; k++) begin
        of_off_r[k] <= -off_t'(rnd30(os_sum_r[k]));
      end
    end
  end

  tpfb_isqrt #(
    .RW (ROOT_W),
    .SW ($bits(side1_t))
  ) u_seam_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (d_v_r),
    .rad      (d_rad_r),
    .side_in  (d_c_r),
    .out_vld  (r1_vld),
    .root     (r1_root),
    .side_out (r1_side)
  );

  tpfb_div #(
    .NW (NUM_W),
    .DW (ROOT_W),
    .QW (QUOT_W),
    .NL (LANES),
    .SW ($bits(side2_t))
  ) u_y_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (e_v_r),
    .num      (e_num_r),
    .den      (e_c_r.len),
    .side_in  (e_c_r),
    .out_vld  (q1_vld),
    .quo      (q1_quo),
    .side_out (q1_side)
  );

  tpfb_isqrt #(
    .RW (ROOT_W),
    .SW ($bits(side3_t))
  ) u_perp_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (m_v_r),
    .rad      (m_rad_r),
    .side_in  (m_c_r),
    .out_vld  (r2_vld),
    .root     (r2_root),
    .side_out (r2_side)
  );

  logic [ROOT_W-1:0] n_den;
  assign n_den = ROOT_W'(unsigned'(r2_root));

  root_t n_pn_r;
  always_ff @(posedge clk) begin
    if (en) begin
      n_pn_r <= n_den;
    end
  end

  tpfb_div #(
    .NW (NUM_W),
    .DW (ROOT_W),
    .QW (QUOT_W),
    .NL (LANES),
    .SW ($bits(side4_t))
  ) u_z_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (n_v_r),
    .num      (n_num_r),
    .den      (n_pn_r),
    .side_in  (n_c_r),
    .out_vld  (q2_vld),
    .quo      (q2_quo),
    .side_out (q2_side)
  );

  // three rows per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_busy_r <= 1'b0;
      sr_cnt_r  <= ROW_X;
    end else if (of_v_r && free) begin
      sr_busy_r <= 1'b1;
      sr_cnt_r  <= ROW_X;
    end else if (sr_busy_r && out_ready) begin
      if (sr_cnt_r == ROW_Z) begin
        sr_busy_r <= 1'b0;
      end else begin
        sr_cnt_r <= 2'(sr_cnt_r + 2'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (of_v_r && free) begin
      sr_f_r   <= of_f_r;
      sr_off_r <= of_off_r;
      sr_ok_r  <= of_ok_r;
      sr_len_r <= of_len_r;
    end
  end

  assign out_valid = sr_busy_r;

  always_comb begin
    out_data             = '0;
    out_data.row_index   = sr_cnt_r;
    out_data.frame_valid = sr_ok_r;
    out_data.seam_length = sr_len_r[32:0];
    out_data.last_row    = sr_cnt_r == ROW_Z;
    case (sr_cnt_r)
      ROW_X: begin
        out_data.axis_x     = sr_f_r[0][0];
        out_data.axis_y     = sr_f_r[0][1];
        out_data.axis_z     = sr_f_r[0][2];
        out_data.row_offset = sr_off_r[0];
      end
      ROW_Y: begin
        out_data.axis_x     = sr_f_r[1][0];
        out_data.axis_y     = sr_f_r[1][1];
        out_data.axis_z     = sr_f_r[1][2];
        out_data.row_offset = sr_off_r[1];
      end
      default: begin
        out_data.axis_x     = sr_f_r[2][0];
        out_data.axis_y     = sr_f_r[2][1];
        out_data.axis_z     = sr_f_r[2][2];
        out_data.row_offset = sr_off_r[2];
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_row_code: assert property (@(posedge clk) disable iff (!rst_n)
    sr_busy_r |-> (sr_cnt_r == ROW_X || sr_cnt_r == ROW_Y || sr_cnt_r == ROW_Z))
    else $error("row counter out of range");

  a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
    sr_busy_r && !out_ready |=> sr_busy_r && $stable(sr_cnt_r))
    else $error("row lost while stalled");

  a_zero_rows: assert property (@(posedge clk) disable iff (!rst_n)
    sr_busy_r && !sr_ok_r |-> out_data.axis_x == '0 && out_data.axis_y == '0 &&
      out_data.axis_z == '0 && out_data.row_offset == '0)
    else $error("degenerate frame with non-zero row");

  a_tail_held: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> of_v_r)
    else $error("pipeline tail dropped during stall");
`endif

endmodule

/* tb/sv/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tpfb_pkg::*;

  localparam int MM = 65536;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_MIN_SEAM;
  logic [CFG_W-1:0] cfg_wdata = '0;

  three_point_frame_builder_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  in_item_t pending_points[$];
  out_item_t expected_rows[$];
  logic [CFG_W-1:0] seam_min = MIN_SEAM_RST;
  logic [CFG_W-1:0] surf_min = MIN_SURF_RST;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int rows_seen = 0;
  int frames_valid = 0;
  int frames_taken = 0;
  int quiet_cycles = 0;

  function automatic logic [63:0] mag64(longint v);
    logic [63:0] m;
    m = v;
    if (v < 0) m = ~m + 64'd1;
    return m;
  endfunction

  function automatic longint rs30(longint v);
    logic [63:0] m;
    m = (mag64(v) + 64'h2000_0000) >> 30;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [63:0] isqrt3(longint a, longint b, longint c);
    logic [127:0] sum, sq;
    logic [63:0] r, cand;
    sum = {64'd0, mag64(a)} * {64'd0, mag64(a)} + {64'd0, mag64(b)} * {64'd0, mag64(b)}
        + {64'd0, mag64(c)} * {64'd0, mag64(c)};
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = r | (64'd1 << i);
      sq = {64'd0, cand} * {64'd0, cand};
      if (sq <= sum) r = cand;
    end
    return r;
  endfunction

  function automatic longint unit_part(longint v, logic [63:0] len);
    logic [63:0] q;
    q = ((mag64(v) << 30) + (len >> 1)) / len;
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint dot_wrap(longint a0, longint a1, longint a2,
                                      longint b0, longint b1, longint b2);
    return a0 * b0 + a1 * b1 + a2 * b2;
  endfunction

  function automatic void predict_frame(in_item_t it);
    longint s[3], d[3], v[3], perp[3], ax[3][3];
    longint proj, off;
    logic [63:0] len, pn;
    logic ok;
    out_item_t r;
    s[0] = it.start_x; s[1] = it.start_y; s[2] = it.start_z;
    d[0] = longint'(it.end_x) - s[0];
    d[1] = longint'(it.end_y) - s[1];
    d[2] = longint'(it.end_z) - s[2];
    v[0] = longint'(it.surface_x) - s[0];
    v[1] = longint'(it.surface_y) - s[1];
    v[2] = longint'(it.surface_z) - s[2];
    for (int k = 0; k < 3; k++)
      for (int i = 0; i < 3; i++) ax[k][i] = 0;
    len = isqrt3(d[0], d[1], d[2]);
    ok = (len != 0) && (len >= {33'd0, seam_min});
    if (ok) begin
      for (int i = 0; i < 3; i++) ax[1][i] = unit_part(d[i], len);
      proj = rs30(dot_wrap(v[0], v[1], v[2], ax[1][0], ax[1][1], ax[1][2]));
      for (int i = 0; i < 3; i++) perp[i] = v[i] - rs30(proj * ax[1][i]);
      pn = isqrt3(perp[0], perp[1], perp[2]);
      if (pn == 0 || pn < {33'd0, surf_min}) begin
        ok = 1'b0;
        for (int i = 0; i < 3; i++) ax[1][i] = 0;
      end else begin
        for (int i = 0; i < 3; i++) ax[2][i] = unit_part(perp[i], pn);
        if (dot_wrap(v[0], v[1], v[2], ax[2][0], ax[2][1], ax[2][2]) < 0)
          for (int i = 0; i < 3; i++) ax[2][i] = -ax[2][i];
        ax[0][0] = rs30(ax[1][1] * ax[2][2] - ax[1][2] * ax[2][1]);
        ax[0][1] = rs30(ax[1][2] * ax[2][0] - ax[1][0] * ax[2][2]);
        ax[0][2] = rs30(ax[1][0] * ax[2][1] - ax[1][1] * ax[2][0]);
      end
    end
    for (int k = 0; k < 3; k++) begin
      off = ok ? -rs30(dot_wrap(ax[k][0], ax[k][1], ax[k][2], s[0], s[1], s[2])) : 0;
      r.row_index = (k == 0) ? ROW_X : (k == 1) ? ROW_Y : ROW_Z;
      r.axis_x = ax[k][0][31:0];
      r.axis_y = ax[k][1][31:0];
      r.axis_z = ax[k][2][31:0];
      r.row_offset = off[39:0];
      r.frame_valid = ok;
      r.seam_length = len[32:0];
      r.last_row = (k == 2);
      expected_rows.push_back(r);
    end
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
  endtask

  // driver and input-side prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_frame(in_data);
        frames_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_points.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        rows_seen++;
        if (expected_rows.size() == 0) begin
          report_mismatch("unexpected row", out_data.row_index, 0);
        end else begin
          want = expected_rows.pop_front();
          if (out_data.row_index !== want.row_index)
            report_mismatch("row_index", out_data.row_index, want.row_index);
          if (out_data.axis_x !== want.axis_x)
            report_mismatch("axis_x", out_data.axis_x, want.axis_x);
          if (out_data.axis_y !== want.axis_y)
            report_mismatch("axis_y", out_data.axis_y, want.axis_y);
          if (out_data.axis_z !== want.axis_z)
            report_mismatch("axis_z", out_data.axis_z, want.axis_z);
          if (out_data.row_offset !== want.row_offset)
            report_mismatch("row_offset", out_data.row_offset, want.row_offset);
          if (out_data.frame_valid !== want.frame_valid)
            report_mismatch("frame_valid", out_data.frame_valid, want.frame_valid);
          if (out_data.seam_length !== want.seam_length)
            report_mismatch("seam_length", out_data.seam_length, want.seam_length);
          if (out_data.last_row !== want.last_row)
            report_mismatch("last_row", out_data.last_row, want.last_row);
          if (want.frame_valid && want.last_row) frames_valid++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (pending_points.size() == 0 && expected_rows.size() == 0 && !in_valid))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress, %0d rows still expected", expected_rows.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic in_item_t mk(int sx, int sy, int sz, int ex, int ey, int ez,
                                  int px, int py, int pz);
    in_item_t it;
    it.start_x = sx; it.start_y = sy; it.start_z = sz;
    it.end_x = ex; it.end_y = ey; it.end_z = ez;
    it.surface_x = px; it.surface_y = py; it.surface_z = pz;
    return it;
  endfunction

  function automatic int coord();
    int v;
    v = $urandom;
    case ($urandom_range(9))
      0, 1: return v;
      default: return v >>> $urandom_range(10, 30);
    endcase
  endfunction

  function automatic in_item_t random_frame();
    int s[3], e[3], p[3];
    int sh;
    for (int i = 0; i < 3; i++) begin
      s[i] = coord();
      sh = $urandom_range(8, 28);
      e[i] = s[i] + ($signed($urandom) >>> (32 - sh));
      p[i] = s[i] + ($signed($urandom) >>> (32 - sh));
    end
    case ($urandom_range(9))
      0: for (int i = 0; i < 3; i++)
           p[i] = s[i] + (e[i] - s[i]) / 2 + int'($urandom_range(0, 3));
      1: for (int i = 0; i < 3; i++) e[i] = s[i] + ($signed($urandom) >>> 14);
      2: for (int i = 0; i < 3; i++) begin
           e[i] = $urandom; p[i] = $urandom; s[i] = $urandom;
         end
      default: ;
    endcase
    return mk(s[0], s[1], s[2], e[0], e[1], e[2], p[0], p[1], p[2]);
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MIN_SEAM) seam_min = val;
    else surf_min = val;
  endtask

  task automatic wait_drained();
    while (pending_points.size() > 0 || in_valid || expected_rows.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [CFG_W-1:0] seam_set[4], surf_set[4];
    int send_set[4], recv_set[4];
    seam_set = '{31'd65536, 31'd0, 31'h7fff_ffff, 31'd200 * MM};
    surf_set = '{31'd32768, 31'd0, 31'h7fff_ffff, 31'd3 * MM};
    send_set = '{0, 86, 0, 12};
    recv_set = '{0, 0, 86, 12};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, directed corners
    pending_points.push_back(mk(0, 0, 0, 0, 0, 0, MM, 0, 0));
    pending_points.push_back(mk(0, 0, 0, 100 * MM, 0, 0, 0, 0, 10 * MM));
    pending_points.push_back(mk(0, 0, 0, 100 * MM, 0, 0, 0, 0, -10 * MM));
    pending_points.push_back(mk(5 * MM, 7 * MM, -3 * MM, 5 * MM, 57 * MM, -3 * MM,
                                20 * MM, 30 * MM, -3 * MM));
    pending_points.push_back(mk(0, 0, 0, MM, 0, 0, 0, MM, 0));
    pending_points.push_back(mk(0, 0, 0, MM - 1, 0, 0, 0, MM, 0));
    pending_points.push_back(mk(0, 0, 0, 0, 0, 10 * MM, 0, 32768, 5 * MM));
    pending_points.push_back(mk(0, 0, 0, 0, 0, 10 * MM, 0, 32767, 5 * MM));
    pending_points.push_back(mk(0, 0, 0, 10 * MM, 10 * MM, 0, 5 * MM, 5 * MM, 0));
    pending_points.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                32'h7fff_ffff, 32'h8000_0000, 0));
    pending_points.push_back(mk(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                                32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                                32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
    pending_points.push_back(mk(-1, -1, -1, 1, 1, 1, -1, 1, 1));
    pending_points.push_back(mk(32'hffff_ffff, 0, 32'h8000_0000, 0, 32'h7fff_ffff, 0,
                                32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    pending_points.push_back(mk(3 * MM, -4 * MM, 12 * MM, 3 * MM, -4 * MM, 12 * MM,
                                9 * MM, 9 * MM, 9 * MM));
    pending_points.push_back(mk(-20 * MM, 40 * MM, 7 * MM, 60 * MM, -10 * MM, 90 * MM,
                                -15 * MM, -30 * MM, 2 * MM));
    pending_points.push_back(mk(1000 * MM, 1000 * MM, 0, 1000 * MM, 1000 * MM, MM,
                                1000 * MM, 1000 * MM + 32768, 0));

    for (int ph = 0; ph < 4; ph++) begin
      if (ph > 0) begin
        wait_drained();
        write_reg(CFG_MIN_SEAM, seam_set[ph]);
        write_reg(CFG_MIN_SURF, surf_set[ph]);
      end
      send_idle_pct = send_set[ph];
      recv_stall_pct = recv_set[ph];
      for (int n = 0; n < 46; n++) pending_points.push_back(random_frame());
    end
    // last pass with both idling and the reset settings again
    wait_drained();
    write_reg(CFG_MIN_SEAM, MIN_SEAM_RST);
    write_reg(CFG_MIN_SURF, MIN_SURF_RST);
    for (int n = 0; n < 10; n++) pending_points.push_back(random_frame());
    wait_drained();

    $display("%0d frames driven over five threshold settings and four flow patterns,",
             frames_taken);
    $display("%0d rows checked, %0d frames built, %0d mismatches", rows_seen,
             frames_valid, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

/* files.f */
src/tpfb_pkg.sv
src/tpfb_isqrt.sv
src/tpfb_div.sv
src/three_point_frame_builder_unit.sv
tb/sv/tb.sv
